/* src/lpht_pkg.sv */
// shared types, widths and codes for the linear probing hash table
`timescale 1ns / 1ps

package lpht_pkg;

    // field widths
    localparam int KEY_W   = 40;
    localparam int PAY_W   = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;

    // default table depth
    localparam int TABLE_SIZE_DEF = 16;

    // key digits handled by the remainder unit, one per cycle
    localparam int DIGIT_W = 4;
    localparam int DIGITS  = KEY_W / DIGIT_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO_KEY  = 2'd3;

endpackage

/* src/lpht_ram.sv */
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lpht_mod.sv */
// iterative key remainder unit, one key digit per cycle
`timescale 1ns / 1ps

module lpht_mod #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lpht_pkg::KEY_W-1:0]    i_key,
    output logic                          o_busy,
    output logic [$clog2(TABLE_SIZE)-1:0] o_rem
);

    import lpht_pkg::*;

    localparam int IDXW = $clog2(TABLE_SIZE);
    localparam int RW   = IDXW + DIGIT_W + 1;
    localparam int DCW  = $clog2(DIGITS + 1);
    localparam logic [RW-1:0] DIV = RW'(TABLE_SIZE);

    logic [KEY_W-1:0] r_key;
    logic [RW-1:0]    r_rem;
    logic [DCW-1:0]   r_left;
    logic             r_busy;
    logic [RW-1:0]    n_rem;

    // shift in the next digit and bring the remainder back below the divisor
    always_comb begin
        logic [RW-1:0] v;
        v = {r_rem[RW-DIGIT_W-1:0], r_key[KEY_W-1 -: DIGIT_W]};
        for (int j = DIGIT_W - 1; j >= 0; j--) begin
            if (v >= (DIV << j)) begin
                v = v - (DIV << j);
            end
        end
        n_rem = v;
    end

    // digit sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_left <= DCW'(DIGITS);
            r_key  <= i_key;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_key  <= r_key << DIGIT_W;
            r_left <= r_left - 1'b1;
            if (r_left == DCW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem[IDXW-1:0];

endmodule

/* src/linear_probe_hash_table.sv */
// linear probing hash table top level: command sequencer, key and payload stores
// sequence: the remainder unit finds the home slot, then each slot probed is read and then checked;
//   search, delete and insert each probe at most TABLE_SIZE slots
// throughput: one item at a time; a new command is accepted only in the idle state
// reset: synchronous, active low; afterwards a clearing pass over every slot
//   empties the key store while no item is accepted
`timescale 1ns / 1ps

module linear_probe_hash_table #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data,
    // command channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lpht_pkg::CMD_W-1:0]  i_cmd,
    input  logic [lpht_pkg::KEY_W-1:0]  i_lookup_key,
    input  logic [lpht_pkg::PAY_W-1:0]  i_record_payload,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lpht_pkg::STAT_W-1:0] o_status,
    output logic [lpht_pkg::SLOT_W-1:0] o_slot_index,
    output logic [lpht_pkg::CNT_W-1:0]  o_probe_count,
    output logic [lpht_pkg::PAY_W-1:0]  o_found_payload
);

    import lpht_pkg::*;

    localparam int IDXW = $clog2(TABLE_SIZE);
    localparam int CW   = $clog2(TABLE_SIZE + 1);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_MOD,
        S_HOME_RD,
        S_HOME_CHK,
        S_OCC_MOD,
        S_FREE_RD,
        S_FREE_CHK,
        S_WR_NEW,
        S_FIND_RD,
        S_FIND_CHK,
        S_DONE
    } t_state;

    t_state            r_state;
    logic              r_replace_mode;
    logic [CMD_W-1:0]  r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [PAY_W-1:0]  r_pay;
    logic [KEY_W-1:0]  r_occ_key;
    logic [PAY_W-1:0]  r_occ_pay;
    logic              r_displace;
    logic [IDXW-1:0]   r_home;
    logic [IDXW-1:0]   r_ptr;
    logic [CW-1:0]     r_cnt;
    logic [STAT_W-1:0] r_res_status;
    logic [IDXW-1:0]   r_res_slot;
    logic [PAY_W-1:0]  r_res_pay;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [SLOT_W-1:0] r_out_slot;
    logic [CNT_W-1:0]  r_out_cnt;
    logic [PAY_W-1:0]  r_out_pay;

    logic              in_accept;
    logic              out_free;
    logic              cmd_known;
    logic              mod_start;
    logic [KEY_W-1:0]  mod_key;
    logic              mod_busy;
    logic [IDXW-1:0]   mod_rem;
    logic              key_we;
    logic              pay_we;
    logic [IDXW-1:0]   waddr;
    logic [KEY_W-1:0]  key_wdata;
    logic [PAY_W-1:0]  pay_wdata;
    logic [KEY_W-1:0]  key_rd;
    logic [PAY_W-1:0]  pay_rd;
    logic [CW-1:0]     n_cnt;
    logic [IDXW-1:0]   n_ptr;
    logic [CW+4:0]     cnt_wide;

    // next slot, wrapping round the table
    function automatic logic [IDXW-1:0] next_slot(input logic [IDXW-1:0] s);
        return (s == IDXW'(TABLE_SIZE - 1)) ? '0 : s + 1'b1;
    endfunction

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign cmd_known = (i_cmd == CMD_INSERT) || (i_cmd == CMD_SEARCH)
                    || (i_cmd == CMD_DELETE);
    assign n_cnt     = r_cnt + 1'b1;
    assign n_ptr     = next_slot(r_ptr);
    assign cnt_wide  = (CW + 5)'(r_cnt);

    // shared remainder unit for home slots
    lpht_mod #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (mod_key),
        .o_busy  (mod_busy),
        .o_rem   (mod_rem)
    );

    // key store, emptied by the clearing pass
    lpht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (r_ptr),
        .o_rdata (key_rd)
    );

    // payload store, read at the same slot as the key store
    lpht_ram #(
        .WIDTH (PAY_W),
        .DEPTH (TABLE_SIZE)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (waddr),
        .i_wdata (pay_wdata),
        .i_raddr (r_ptr),
        .o_rdata (pay_rd)
    );

    // store writes and remainder unit starts
    always_comb begin
        mod_start = 1'b0;
        mod_key   = i_lookup_key;
        key_we    = 1'b0;
        pay_we    = 1'b0;
        waddr     = r_ptr;
        key_wdata = r_key;
        pay_wdata = r_pay;
        unique case (r_state)
            S_CLR: begin
                key_we    = 1'b1;
                key_wdata = '0;
            end
            S_IDLE: begin
                if (i_in_valid && (i_lookup_key != '0) && cmd_known) begin
                    mod_start = 1'b1;
                end
            end
            S_HOME_CHK: begin
                if (key_rd == '0) begin
                    key_we = 1'b1;
                    pay_we = 1'b1;
                end else if (r_replace_mode) begin
                    mod_start = 1'b1;
                    mod_key   = key_rd;
                end
            end
            S_FREE_CHK: begin
                if (key_rd == '0) begin
                    key_we = 1'b1;
                    pay_we = 1'b1;
                    if (r_displace) begin
                        key_wdata = r_occ_key;
                        pay_wdata = r_occ_pay;
                    end
                end
            end
            S_WR_NEW: begin
                key_we = 1'b1;
                pay_we = 1'b1;
                waddr  = r_home;
            end
            S_FIND_CHK: begin
                if ((key_rd == r_key) && (r_cmd == CMD_DELETE)) begin
                    key_we    = 1'b1;
                    key_wdata = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replace_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_replace_mode <= i_cfg_wr_data;
        end
    end

    // command sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken; a fresh one from the done state refills it instead
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_ptr <= n_ptr;
                    if (r_ptr == IDXW'(TABLE_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd        <= i_cmd;
                        r_key        <= i_lookup_key;
                        r_pay        <= i_record_payload;
                        r_cnt        <= '0;
                        r_res_slot   <= '0;
                        r_res_pay    <= '0;
                        if (i_lookup_key == '0) begin
                            r_res_status <= ST_ZERO_KEY;
                            r_state      <= S_DONE;
                        end else if (!cmd_known) begin
                            r_res_status <= ST_NOT_FOUND;
                            r_state      <= S_DONE;
                        end else begin
                            r_res_status <= ST_OK;
                            r_state      <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (!mod_busy) begin
                        r_home  <= mod_rem;
                        r_ptr   <= mod_rem;
                        r_state <= (r_cmd == CMD_INSERT) ? S_HOME_RD : S_FIND_RD;
                    end
                end
                S_HOME_RD: begin
                    r_state <= S_HOME_CHK;
                end
                S_HOME_CHK: begin
                    r_cnt <= CW'(1);
                    if (key_rd == '0) begin
                        r_res_slot <= r_ptr;
                        r_state    <= S_DONE;
                    end else if (r_replace_mode) begin
                        r_occ_key <= key_rd;
                        r_occ_pay <= pay_rd;
                        r_state   <= S_OCC_MOD;
                    end else begin
                        r_displace <= 1'b0;
                        r_ptr      <= n_ptr;
                        r_state    <= S_FREE_RD;
                    end
                end
                S_OCC_MOD: begin
                    if (!mod_busy) begin
                        r_displace <= (mod_rem != r_home);
                        r_ptr      <= n_ptr;
                        r_state    <= S_FREE_RD;
                    end
                end
                S_FREE_RD: begin
                    r_state <= S_FREE_CHK;
                end
                S_FREE_CHK: begin
                    r_cnt <= n_cnt;
                    if (key_rd == '0) begin
                        r_res_slot <= r_displace ? r_home : r_ptr;
                        r_state    <= r_displace ? S_WR_NEW : S_DONE;
                    end else if (n_ptr == r_home) begin
                        r_res_status <= ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_ptr   <= n_ptr;
                        r_state <= S_FREE_RD;
                    end
                end
                S_WR_NEW: begin
                    r_state <= S_DONE;
                end
                S_FIND_RD: begin
                    r_state <= S_FIND_CHK;
                end
                S_FIND_CHK: begin
                    r_cnt <= n_cnt;
                    if (key_rd == r_key) begin
                        r_res_slot <= r_ptr;
                        if (r_cmd == CMD_SEARCH) begin
                            r_res_pay <= pay_rd;
                        end
                        r_state <= S_DONE;
                    end else if (n_cnt == CW'(TABLE_SIZE)) begin
                        r_res_status <= ST_NOT_FOUND;
                        r_state      <= S_DONE;
                    end else begin
                        r_ptr   <= n_ptr;
                        r_state <= S_FIND_RD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_slot   <= SLOT_W'(r_res_slot);
                        r_out_cnt    <= (cnt_wide > (CW + 5)'(31)) ? CNT_W'(31)
                                                                   : CNT_W'(cnt_wide);
                        r_out_pay    <= r_res_pay;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot_index    = r_out_slot;
    assign o_probe_count   = r_out_cnt;
    assign o_found_payload = r_out_pay;

endmodule
